FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the deque core; empty bodies when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every edge outside reset
`define ORDL_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("deque assertion failed");

// Antecedent implies consequent in the next cycle
`define ORDL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`else

`define ORDL_ASSERT(lbl, cond)
`define ORDL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/ordl_pkg.sv
// ----------------------------------------------------------------------------
// ordl_pkg
// Shared types and constants of the output restricted deque core.
// ----------------------------------------------------------------------------
package ordl_pkg;

    // Buffer geometry
    localparam int DEPTH  = 16;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    // Command codes
    typedef enum logic [1:0] {
        ACT_PUSH_HEAD = 2'd0,
        ACT_PUSH_TAIL = 2'd1,
        ACT_POP       = 2'd2,
        ACT_DUMP      = 2'd3
    } action_t;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic [OCC_W-1:0]         occupancy;
        logic                     last;
    } result_t;

endpackage

FILE: hdl/ordl_ram.sv
// ----------------------------------------------------------------------------
// ordl_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ordl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/ordl_ctrl.sv
// ----------------------------------------------------------------------------
// ordl_ctrl
// Sequencer and pointer state; one shared wrap-around step unit moves
// the head, tail and dump walk pointers.
// ----------------------------------------------------------------------------
module ordl_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  ordl_pkg::cmd_t                cmd,
    output logic                          busy,
    output logic                          ram_we,
    output logic [ordl_pkg::PTR_W-1:0]    ram_waddr,
    output logic [ordl_pkg::DATA_W-1:0]   ram_wdata,
    output logic [ordl_pkg::PTR_W-1:0]    ram_raddr,
    input  logic [ordl_pkg::DATA_W-1:0]   ram_rdata,
    output logic                          res_load,
    output ordl_pkg::result_t             res_next
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_DUMP = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [ordl_pkg::PTR_W-1:0]   head_reg, head_next;
    logic [ordl_pkg::PTR_W-1:0]   tail_reg, tail_next;
    logic [ordl_pkg::PTR_W-1:0]   walk_reg, walk_next;
    logic [ordl_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [ordl_pkg::CNT_W-1:0]   left_reg, left_next;

    logic                         accept;
    logic                         full;
    logic                         empty;
    logic [ordl_pkg::PTR_W-1:0]   step_src;
    logic                         step_up;
    logic [ordl_pkg::PTR_W-1:0]   step_out;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign full   = (count_reg == ordl_pkg::CNT_W'(ordl_pkg::DEPTH));
    assign empty  = (count_reg == '0);

    // Operand select for the shared step unit
    always_comb
    begin
        step_src = head_reg;
        step_up  = 1'b1;
        if (state_reg == S_DUMP)
        begin
            step_src = walk_reg;
        end
        else if (cmd.action == ordl_pkg::ACT_PUSH_HEAD)
        begin
            step_up = 1'b0;
        end
        else if (cmd.action == ordl_pkg::ACT_PUSH_TAIL)
        begin
            step_src = tail_reg;
        end
    end

    // Shared step unit: +1 or -1 modulo DEPTH
    always_comb
    begin
        if (step_up)
        begin
            step_out = (step_src == ordl_pkg::PTR_W'(ordl_pkg::DEPTH - 1)) ?
                       '0 : step_src + 1'b1;
        end
        else
        begin
            step_out = (step_src == '0) ?
                       ordl_pkg::PTR_W'(ordl_pkg::DEPTH - 1) : step_src - 1'b1;
        end
    end

    assign ram_raddr = (state_reg == S_DUMP) ? walk_reg : head_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        walk_next  = walk_reg;
        count_next = count_reg;
        left_next  = left_reg;
        ram_we     = 1'b0;
        ram_waddr  = tail_reg;
        ram_wdata  = cmd.value;
        res_load   = 1'b0;
        res_next   = '{status: ordl_pkg::STAT_OK, data: '0,
                       occupancy: ordl_pkg::OCC_W'(count_reg), last: 1'b1};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.action)
                        ordl_pkg::ACT_PUSH_HEAD,
                        ordl_pkg::ACT_PUSH_TAIL:
                        begin
                            res_load = 1'b1;
                            if (full)
                            begin
                                res_next.status = ordl_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                res_next.occupancy = ordl_pkg::OCC_W'(count_next);
                                if (cmd.action == ordl_pkg::ACT_PUSH_HEAD)
                                begin
                                    ram_waddr = step_out;
                                    head_next = step_out;
                                end
                                else
                                begin
                                    tail_next = step_out;
                                end
                            end
                        end
                        ordl_pkg::ACT_POP:
                        begin
                            if (empty)
                            begin
                                res_load        = 1'b1;
                                res_next.status = ordl_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                // word at head comes back next cycle
                                head_next  = step_out;
                                count_next = count_reg - 1'b1;
                                state_next = S_POP;
                            end
                        end
                        ordl_pkg::ACT_DUMP:
                        begin
                            if (empty)
                            begin
                                res_load        = 1'b1;
                                res_next.status = ordl_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                walk_next  = step_out;
                                left_next  = count_reg;
                                state_next = S_DUMP;
                            end
                        end
                    endcase
                end
            end
            S_POP:
            begin
                res_load      = 1'b1;
                res_next.data = ram_rdata;
                state_next    = S_IDLE;
            end
            S_DUMP:
            begin
                // one element per cycle, next read already issued
                res_load      = 1'b1;
                res_next.data = ram_rdata;
                res_next.last = (left_reg == ordl_pkg::CNT_W'(1));
                walk_next     = step_out;
                left_next     = left_reg - 1'b1;
                if (left_reg == ordl_pkg::CNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            walk_reg  <= '0;
            count_reg <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            walk_reg  <= walk_next;
            count_reg <= count_next;
            left_reg  <= left_next;
        end
    end

endmodule

FILE: hdl/output_restricted_deque_core.sv
// ----------------------------------------------------------------------------
// output_restricted_deque_core
// Circular buffer of signed words, pushed at head or tail, popped at head.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (action, value) is taken on a rising edge with
//   start high and busy low. Result channel: each result item is shown for
//   one cycle with done high; the receiver cannot stall it.
// Per action:
//   Push (either end) and refused actions: result in the cycle after
//   accept; busy stays low, so one item per cycle.
//   Pop: busy is high for one cycle, in S_POP; the result passes the
//   registered read port and then the result register.
//   Dump of N elements: busy is high in S_DUMP until the last of the N
//   results is loaded; the first result follows the registered read port,
//   then one per cycle. The walk reads one element per cycle from the RAM.
// Reset:
//   Pointers and count go to zero and the buffer is empty; stored words
//   are undefined until written. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module output_restricted_deque_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ordl_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done,
    output ordl_pkg::result_t result
);

    logic                          ram_we;
    logic [ordl_pkg::PTR_W-1:0]    ram_waddr;
    logic [ordl_pkg::DATA_W-1:0]   ram_wdata;
    logic [ordl_pkg::PTR_W-1:0]    ram_raddr;
    logic [ordl_pkg::DATA_W-1:0]   ram_rdata;
    logic                          res_load;
    ordl_pkg::result_t             res_next;
    logic                          done_reg;
    ordl_pkg::result_t             result_reg;

    ordl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_load  (res_load),
        .res_next  (res_next)
    );

    ordl_ram #(
        .WIDTH (ordl_pkg::DATA_W),
        .DEPTH (ordl_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            result_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    `ORDL_ASSERT_NEXT(a_push_one_cycle,
        start && !busy && (cmd.action == ordl_pkg::ACT_PUSH_HEAD ||
                           cmd.action == ordl_pkg::ACT_PUSH_TAIL),
        done && result.last)
    `ORDL_ASSERT_NEXT(a_dump_contiguous, done && !result.last, done)
    `ORDL_ASSERT(a_full_occupancy,
        !(done && result.status == ordl_pkg::STAT_FULL) ||
        result.occupancy == ordl_pkg::OCC_W'(ordl_pkg::DEPTH))
    `ORDL_ASSERT(a_empty_result,
        !(done && result.status == ordl_pkg::STAT_EMPTY) ||
        (result.occupancy == '0 && result.last))

endmodule
